[design/psad_pkg.sv]
// ----------------------------------------------------------------------------
// psad_pkg
// Shared constants for the plucked string allpass delay block: register
// indexes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package psad_pkg;

    localparam int DELAY_DEPTH_DEF    = 4096;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int OFFSET_BITS        = 12;
    localparam int COEFF_BITS         = 16;
    localparam int COEFF_FRAC         = 15;
    localparam int DELAY_OFFSET_RESET = 100;

    localparam int CFG_DATA_BITS      = 16;
    localparam int CFG_INDEX_BITS     = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_OFFSET  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALLPASS_COEFF = 1'd1;

endpackage

`default_nettype wire

[design/psad_ring.sv]
// ----------------------------------------------------------------------------
// psad_ring
// Delay ring memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module psad_ring #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int W     = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr1,
    input  wire logic [AW-1:0] raddr2,
    output logic      [W-1:0]  rdata1,
    output logic      [W-1:0]  rdata2
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd1_reg;
    logic [W-1:0] rd2_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd1_reg <= mem[raddr1];
            rd2_reg <= mem[raddr2];
        end
    end

    assign rdata1 = rd1_reg;
    assign rdata2 = rd2_reg;

endmodule

`default_nettype wire

[design/psad_cfg.sv]
// ----------------------------------------------------------------------------
// psad_cfg
// Configuration registers. The delay offset is reduced modulo the ring
// depth when it is written, so the address path only sees in-range offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module psad_cfg #(
    parameter int DELAY_DEPTH = 4096,
    parameter int AW          = 12
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  we,
    input  wire logic [psad_pkg::CFG_INDEX_BITS-1:0]   index,
    input  wire logic [psad_pkg::CFG_DATA_BITS-1:0]    data,
    output logic      [AW-1:0]                         offset,
    output logic signed [psad_pkg::COEFF_BITS-1:0]     coeff
);

    import psad_pkg::*;

    localparam int RSHIFT   = 24;
    localparam int PW       = OFFSET_BITS + RSHIFT;
    localparam int QW       = RSHIFT;
    localparam bit IN_RANGE = DELAY_DEPTH > ((1 << OFFSET_BITS) - 1);
    localparam longint unsigned RECIP =
        ((longint'(1) << RSHIFT) + longint'(DELAY_DEPTH) - 1) / longint'(DELAY_DEPTH);
    localparam logic [AW-1:0] OFF_RESET = AW'(DELAY_OFFSET_RESET % DELAY_DEPTH);

    logic [OFFSET_BITS-1:0]       raw_off;
    logic [PW-1:0]                quot_prod;
    logic [OFFSET_BITS-1:0]       quot;
    logic [QW-1:0]                quot_depth;
    logic [QW-1:0]                rem;
    logic [AW-1:0]                off_red;
    logic [AW-1:0]                offset_reg;
    logic signed [COEFF_BITS-1:0] coeff_reg;

    always_comb
    begin
        raw_off    = data[OFFSET_BITS-1:0];
        quot_prod  = PW'(raw_off) * PW'(RECIP);
        quot       = quot_prod[PW-1:RSHIFT];
        quot_depth = QW'(quot) * QW'(DELAY_DEPTH);
        rem        = QW'(raw_off) - quot_depth;
        off_red    = IN_RANGE ? AW'(raw_off) : AW'(rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFF_RESET;
            coeff_reg  <= '0;
        end
        else if (we)
        begin
            case (index)
                REG_DELAY_OFFSET:  offset_reg <= off_red;
                REG_ALLPASS_COEFF: coeff_reg  <= $signed(data[COEFF_BITS-1:0]);
                default:           ;
            endcase
        end
    end

    assign offset = offset_reg;
    assign coeff  = coeff_reg;

endmodule

`default_nettype wire

[design/psad_allpass.sv]
// ----------------------------------------------------------------------------
// psad_allpass
// Tap averaging, first-order allpass and loop sample saturation. Holds the
// previous average and the previous allpass output.
// ----------------------------------------------------------------------------
`default_nettype none

module psad_allpass #(
    parameter int SB = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic signed [psad_pkg::COEFF_BITS-1:0] coeff,
    input  wire logic [SB-1:0]                       tap1,
    input  wire logic [SB-1:0]                       tap2,
    input  wire logic [SB-1:0]                       sample,
    output logic      [SB-1:0]                       y,
    output logic      [SB-1:0]                       loop_sample
);

    import psad_pkg::*;

    localparam int PW = SB + COEFF_BITS + 1;
    localparam logic [SB-1:0] SAT_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SAT_LO = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF = PW'(1) << (COEFF_FRAC - 1);

    logic [SB-1:0]           prev_average_reg;
    logic [SB-1:0]           allpass_out_reg;
    logic signed [SB:0]      tap_sum;
    logic [SB-1:0]           avg;
    logic signed [SB:0]      diff;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_rnd;
    logic signed [SB+1:0]    scaled;
    logic signed [SB+2:0]    y_wide;
    logic [SB-1:0]           y_sat;
    logic signed [SB:0]      loop_wide;

    always_comb
    begin
        tap_sum  = $signed({tap1[SB-1], tap1}) + $signed({tap2[SB-1], tap2});
        avg      = tap_sum[SB:1];
        diff     = $signed({avg[SB-1], avg}) -
                   $signed({allpass_out_reg[SB-1], allpass_out_reg});
        prod     = $signed({{(COEFF_BITS){diff[SB]}}, diff}) *
                   $signed({{(SB+1){coeff[COEFF_BITS-1]}}, coeff});
        prod_rnd = prod + HALF;
        scaled   = prod_rnd[PW-1:COEFF_FRAC];
        y_wide   = $signed({scaled[SB+1], scaled}) +
                   $signed({{3{prev_average_reg[SB-1]}}, prev_average_reg});
        if (y_wide[SB+2:SB-1] == '0 || y_wide[SB+2:SB-1] == '1)
        begin
            y_sat = y_wide[SB-1:0];
        end
        else
        begin
            y_sat = y_wide[SB+2] ? SAT_LO : SAT_HI;
        end
        loop_wide = $signed({sample[SB-1], sample}) + $signed({y_sat[SB-1], y_sat});
        if (loop_wide[SB] != loop_wide[SB-1])
        begin
            loop_sample = loop_wide[SB] ? SAT_LO : SAT_HI;
        end
        else
        begin
            loop_sample = loop_wide[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_average_reg <= '0;
            allpass_out_reg  <= '0;
        end
        else if (en)
        begin
            prev_average_reg <= avg;
            allpass_out_reg  <= y_sat;
        end
    end

    assign y = y_sat;

endmodule

`default_nettype wire

[design/plucked_string_allpass_delay.sv]
// ----------------------------------------------------------------------------
// plucked_string_allpass_delay
// Plucked string loop: two ring taps are averaged, passed through a
// first-order allpass, and the excitation plus the allpass output is written
// back into the ring.
//
//   Channel   Dir  Fields (tdata, lowest bit up)        Transaction
//   s_axis    in   sample_in                            tvalid & tready
//   m_axis    out  sample_out                           tvalid & tready
//   cfg       in   index 0 delay_offset, 1 allpass_coeff cfg_we
//
// One transaction per cycle is sustained while the output is not stalled. The
// edge that accepts a sample registers its ring read, and its allpass output is
// registered into the output register when the allpass stage advances. The
// allpass state it leaves feeds the next sample.
// The ring is not cleared after reset: slots that were never written read as
// zero through the write pointer and a wrap flag.
// A stalled output holds one result and one more sample in the allpass stage.
// ----------------------------------------------------------------------------
`default_nettype none

module plucked_string_allpass_delay #(
    parameter int DELAY_DEPTH = psad_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = psad_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // sample_in
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // sample_out
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [psad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [psad_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import psad_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int AW     = $clog2(DELAY_DEPTH);
    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);

    logic [AW-1:0]                offset;
    logic signed [COEFF_BITS-1:0] coeff;

    logic [AW-1:0]   wp_reg;
    logic            wrapped_reg;
    logic            b_valid_reg;
    logic [SB-1:0]   b_sample_reg;
    logic [AW-1:0]   b_waddr_reg;
    logic            b_fwd1_reg;
    logic            b_fwd2_reg;
    logic            b_vld1_reg;
    logic            b_vld2_reg;
    logic [SB-1:0]   b_fdata_reg;
    logic            out_valid_reg;
    logic [SB-1:0]   out_data_reg;

    logic            accept;
    logic            b_adv;
    logic [AW:0]     back1;
    logic [AW-1:0]   p1;
    logic [AW-1:0]   p2;
    logic [AW-1:0]   wp_next;
    logic [SB-1:0]   rd1;
    logic [SB-1:0]   rd2;
    logic [SB-1:0]   tap1;
    logic [SB-1:0]   tap2;
    logic [SB-1:0]   y;
    logic [SB-1:0]   loop_sample;

    psad_cfg #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .AW          (AW)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (cfg_we),
        .index  (cfg_index),
        .data   (cfg_data),
        .offset (offset),
        .coeff  (coeff)
    );

    always_comb
    begin
        b_adv         = b_valid_reg && (!out_valid_reg || m_axis_tready);
        s_axis_tready = !b_valid_reg || b_adv;
        accept        = s_axis_tvalid && s_axis_tready;
        back1         = {1'b0, wp_reg} - {1'b0, offset};
        p1            = back1[AW] ? AW'(back1 + (AW+1)'(DELAY_DEPTH)) : back1[AW-1:0];
        p2            = (p1 == '0) ? LAST_POS : p1 - AW'(1);
        wp_next       = (wp_reg == LAST_POS) ? '0 : wp_reg + AW'(1);
        tap1          = b_fwd1_reg ? b_fdata_reg : (b_vld1_reg ? rd1 : '0);
        tap2          = b_fwd2_reg ? b_fdata_reg : (b_vld2_reg ? rd2 : '0);
    end

    psad_ring #(
        .DEPTH (DELAY_DEPTH),
        .AW    (AW),
        .W     (SB)
    ) u_ring (
        .clk    (clk),
        .we     (b_adv),
        .waddr  (b_waddr_reg),
        .wdata  (loop_sample),
        .re     (accept),
        .raddr1 (p1),
        .raddr2 (p2),
        .rdata1 (rd1),
        .rdata2 (rd2)
    );

    psad_allpass #(
        .SB (SB)
    ) u_allpass (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (b_adv),
        .coeff       (coeff),
        .tap1        (tap1),
        .tap2        (tap2),
        .sample      (b_sample_reg),
        .y           (y),
        .loop_sample (loop_sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= wp_next;
                if (wp_reg == LAST_POS)
                begin
                    wrapped_reg <= 1'b1;
                end
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sample_reg <= s_axis_tdata[SB-1:0];
            b_waddr_reg  <= wp_reg;
            b_fwd1_reg   <= b_adv && (b_waddr_reg == p1);
            b_fwd2_reg   <= b_adv && (b_waddr_reg == p2);
            b_vld1_reg   <= wrapped_reg || (p1 < wp_reg);
            b_vld2_reg   <= wrapped_reg || (p2 < wp_reg);
            b_fdata_reg  <= loop_sample;
        end
        if (b_adv)
        begin
            out_data_reg <= y;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_data_reg);

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("Input accepted while the allpass stage is stalled.");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> b_valid_reg)
        else $error("Accepted sample did not reach the allpass stage.");

    a_pointer_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
        (wp_reg == (($past(wp_reg) == LAST_POS) ? '0 : $past(wp_reg) + AW'(1))))
        else $error("Write pointer did not advance by one slot.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        b_adv |=> m_axis_tvalid)
        else $error("Finished sample did not appear at the output.");
`endif

endmodule

`default_nettype wire

[verif/psad_checker.sv]
// ----------------------------------------------------------------------------
// psad_checker
// Watches the sample, result and register write channels of the plucked
// string allpass delay block. It predicts every result from its own copy of
// the delay ring, the allpass state and the registers. Each accepted result
// is compared with the oldest prediction, and mismatches are counted.
// ----------------------------------------------------------------------------
module psad_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [15:0]                         m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [psad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [psad_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import psad_pkg::*;

    localparam int SW       = SAMPLE_BITS_DEF;
    localparam int DEPTH    = DELAY_DEPTH_DEF;
    localparam int PTR_BITS = $clog2(DEPTH);

    localparam longint SAMPLE_HI = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

    typedef logic signed [SW-1:0] sample_t;

    sample_t                       ring [DEPTH];
    logic [PTR_BITS-1:0]           head;
    sample_t                       prev_avg;
    sample_t                       last_out;
    logic [OFFSET_BITS-1:0]        offset_reg;
    logic signed [COEFF_BITS-1:0]  coeff_reg;
    sample_t                       expected_out [$];

    function automatic sample_t clamp(input longint v);
        if (v > SAMPLE_HI)
            return sample_t'(SAMPLE_HI);
        if (v < SAMPLE_LO)
            return sample_t'(SAMPLE_LO);
        return sample_t'(v);
    endfunction

    // Both taps are read before the write, so a zero offset sees the old slot.
    function automatic sample_t string_step(input sample_t excitation);
        logic [PTR_BITS-1:0] tap_near;
        logic [PTR_BITS-1:0] tap_far;
        longint              avg;
        longint              prod;
        longint              y;
        tap_near = head - offset_reg;
        tap_far  = tap_near - 1'b1;
        avg  = (longint'(ring[tap_near]) + longint'(ring[tap_far])) >>> 1;
        prod = longint'(coeff_reg) * (avg - longint'(last_out));
        y    = (prod + (longint'(1) << (COEFF_FRAC - 1))) >>> COEFF_FRAC;
        y    = longint'(clamp(y + longint'(prev_avg)));
        ring[head] = clamp(longint'(excitation) + y);
        head     = head + 1'b1;
        prev_avg = sample_t'(avg);
        last_out = sample_t'(y);
        return last_out;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_t got;
        sample_t want;
        if (!rst_n)
        begin
            foreach (ring[i])
                ring[i] = '0;
            head       = '0;
            prev_avg   = '0;
            last_out   = '0;
            offset_reg = OFFSET_BITS'(DELAY_OFFSET_RESET);
            coeff_reg  = '0;
            expected_out.delete();
            fail_count      <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = sample_t'(m_axis_tdata[SW-1:0]);
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected sample_out transaction, expected none, got %0d",
                             $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DELAY_OFFSET:  offset_reg = cfg_data[OFFSET_BITS-1:0];
                    REG_ALLPASS_COEFF: coeff_reg  = cfg_data[COEFF_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_out.push_back(string_step(sample_t'(s_axis_tdata[SW-1:0])));
            pending_results <= expected_out.size();
        end
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Regression for the plucked string allpass delay block. A directed part
// covers extreme samples and register settings. After it come phases of
// random plucks: noise bursts followed by silence, so the loop rings. Each
// phase uses its own offset and coefficient and one of four patterns of
// sender gaps and receiver stalls. Two phases hold the receiver off long
// enough to back the block up. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psad_pkg::*;

    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_GAPS,
        TRAFFIC_RECEIVER_STALLS,
        TRAFFIC_BOTH
    } traffic_t;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_CYCLES = 300;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [15:0]               s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [15:0]               m_axis_tdata;
    logic                      cfg_we        = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = REG_DELAY_OFFSET;
    logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;

    int fail_count;
    int pending_results;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    plucked_string_allpass_delay dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    psad_checker loop_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_sample(input logic [15:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [OFFSET_BITS-1:0] offset_val,
                             input logic [COEFF_BITS-1:0] coeff_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DELAY_OFFSET;
        cfg_data  <= {4'($urandom), offset_val};
        @(posedge clk);
        cfg_index <= REG_ALLPASS_COEFF;
        cfg_data  <= coeff_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly plucks (a noise burst, then silence while the string rings),
    // with short runs of loud noise in between.
    task automatic play_phase(input int count, input bit with_hold);
        int          sent;
        int          burst_left;
        int          quiet_left;
        bit          loud;
        logic [15:0] value;
        sent       = 0;
        burst_left = 0;
        quiet_left = 0;
        loud       = 1'b0;
        while (sent < count)
        begin
            if (burst_left == 0 && quiet_left == 0)
            begin
                loud = ($urandom_range(9) >= 7);
                if (loud)
                    burst_left = $urandom_range(6, 1);
                else
                begin
                    burst_left = $urandom_range(48, 4);
                    quiet_left = $urandom_range(96, 16);
                end
            end
            if (burst_left != 0)
            begin
                burst_left--;
                value = 16'($urandom);
                if (loud && $urandom_range(1) == 0)
                    value = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            end
            else
            begin
                quiet_left--;
                value = 16'h0000;
            end
            if (with_hold && sent == 40)
                hold_requests <= hold_requests + 1;
            push_sample(value);
            sent++;
        end
    endtask

    initial
    begin
        logic [15:0]            reset_set [7];
        logic [OFFSET_BITS-1:0] offset_val;
        logic [COEFF_BITS-1:0]  coeff_val;
        traffic_t               mode;

        reset_set = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (reset_set[i])
            push_sample(reset_set[i]);
        settle();

        configure(12'd0, 16'h7FFF);
        repeat (3) push_sample(16'h7FFF);
        repeat (3) push_sample(16'h8000);
        settle();

        configure(12'd1, 16'h8000);
        repeat (4) push_sample(16'h7FFF);
        repeat (4) push_sample(16'h8000);
        settle();

        configure(12'd4095, 16'h8001);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin offset_val = 12'd7;    coeff_val = 16'h7FFF; end
                1:       begin offset_val = 12'd0;    coeff_val = 16'h8000; end
                2:       begin offset_val = 12'd4095; coeff_val = 16'($urandom); end
                3:       begin offset_val = 12'd1;    coeff_val = 16'h0000; end
                4:       begin offset_val = 12'($urandom_range(64, 2));
                               coeff_val = 16'h4000; end
                5:       begin offset_val = 12'($urandom);
                               coeff_val = 16'($urandom); end
                6:       begin offset_val = 12'($urandom_range(400, 64));
                               coeff_val = 16'hC000; end
                default: begin offset_val = 12'($urandom_range(32, 2));
                               coeff_val = 16'($urandom); end
            endcase
            configure(offset_val, coeff_val);

            mode = traffic_t'(p % 4);
            case (mode)
                TRAFFIC_STEADY:          begin idle_pct = 0;  stall_pct <= 0;  end
                TRAFFIC_SENDER_GAPS:     begin idle_pct = 47; stall_pct <= 0;  end
                TRAFFIC_RECEIVER_STALLS: begin idle_pct = 0;  stall_pct <= 47; end
                default:                 begin idle_pct = 20; stall_pct <= 20; end
            endcase

            play_phase(PHASE_ITEMS, mode == TRAFFIC_STEADY);
            settle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("plucked_string_allpass_delay regression: pass");
        else
            $display("plucked_string_allpass_delay regression: fail");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("plucked_string_allpass_delay regression: fail");
        $finish;
    end

endmodule

[filelist.f]
design/psad_pkg.sv
design/psad_ring.sv
design/psad_cfg.sv
design/psad_allpass.sv
design/plucked_string_allpass_delay.sv
verif/psad_checker.sv
verif/tb.sv
